@@ design/ruci_pkg.sv @@
// Shared constants for the ray / unit circle intersection datapath.
// No dependencies; used by ruci_sqrt and ray_unit_circle_intersect_unit.
package ruci_pkg;

  // Root digits resolved in each register stage of the square root pipeline.
  localparam int unsigned SQRT_STEPS = 2;

  // Number of register stages needed for a root of the given digit count.
  function automatic int unsigned sqrt_stages(input int unsigned digits);
    return (digits + SQRT_STEPS - 1) / SQRT_STEPS;
  endfunction

endpackage

@@ design/ruci_sqrt.sv @@
// Pipelined restoring integer square root, SQRT_STEPS digits per stage,
// with a sideband payload that travels alongside. Depends on ruci_pkg.
module ruci_sqrt #(
  parameter int unsigned DIGITS = 17,
  parameter int unsigned SBW    = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2*DIGITS-1:0]   in_rad,
  input  logic [SBW-1:0]        in_sb,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DIGITS-1:0]     out_root,
  output logic [SBW-1:0]        out_sb
);

  localparam int unsigned NS   = ruci_pkg::sqrt_stages(DIGITS);
  localparam int unsigned RADW = 2 * DIGITS;
  localparam int unsigned RMW  = DIGITS + 3;

  logic [NS-1:0]     v_r;
  logic [NS:0]       rdy;
  logic [NS-1:0]     src_v;
  logic [RADW-1:0]   rad_r    [NS];
  logic [RMW-1:0]    rem_r    [NS];
  logic [DIGITS-1:0] root_r   [NS];
  logic [SBW-1:0]    sb_r     [NS];
  logic [RADW-1:0]   src_rad  [NS];
  logic [RMW-1:0]    src_rem  [NS];
  logic [DIGITS-1:0] src_root [NS];
  logic [SBW-1:0]    src_sb   [NS];
  logic [RMW-1:0]    rem_nxt  [NS];
  logic [DIGITS-1:0] root_nxt [NS];

  assign rdy[NS] = out_ready;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    assign rdy[s] = !v_r[s] || rdy[s+1];

    if (s == 0) begin : g_first
      assign src_v[s]    = in_valid;
      assign src_rad[s]  = in_rad;
      assign src_rem[s]  = '0;
      assign src_root[s] = '0;
      assign src_sb[s]   = in_sb;
    end else begin : g_next
      assign src_v[s]    = v_r[s-1];
      assign src_rad[s]  = rad_r[s-1];
      assign src_rem[s]  = rem_r[s-1];
      assign src_root[s] = root_r[s-1];
      assign src_sb[s]   = sb_r[s-1];
    end

    always_comb begin
      logic [RMW-1:0]    rem_v;
      logic [RMW-1:0]    trial;
      logic [DIGITS-1:0] root_v;
      int unsigned       d;
      rem_v  = src_rem[s];
      root_v = src_root[s];
      trial  = '0;
      d      = 0;
      for (int j = 0; j < int'(ruci_pkg::SQRT_STEPS); j++) begin
        d = s * ruci_pkg::SQRT_STEPS + j;
        if (d < DIGITS) begin
          // bring down the next radicand digit pair, try (4*root + 1)
          rem_v = {rem_v[RMW-3:0], src_rad[s][RADW-1-2*d -: 2]};
          trial = RMW'({root_v, 2'b01});
          if (rem_v >= trial) begin
            rem_v  = rem_v - trial;
            root_v = {root_v[DIGITS-2:0], 1'b1};
          end else begin
            root_v = {root_v[DIGITS-2:0], 1'b0};
          end
        end
      end
      rem_nxt[s]  = rem_v;
      root_nxt[s] = root_v;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_r[s] <= src_v[s];
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[s]) begin
        rad_r[s]  <= src_rad[s];
        rem_r[s]  <= rem_nxt[s];
        root_r[s] <= root_nxt[s];
        sb_r[s]   <= src_sb[s];
      end
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[NS-1];
  assign out_root  = root_r[NS-1];
  assign out_sb    = sb_r[NS-1];

  a_root_low : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((RADW+2)'(out_root) * (RADW+2)'(out_root)
                   <= (RADW+2)'(rad_r[NS-1])))
    else $error("sqrt root too large");

  a_root_high : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (((RADW+2)'(out_root) + 1'b1) * ((RADW+2)'(out_root) + 1'b1)
                   > (RADW+2)'(rad_r[NS-1])))
    else $error("sqrt root too small");

  a_first_load : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted request not captured in first sqrt stage");

endmodule

@@ design/ray_unit_circle_intersect_unit.sv @@
// Ray against the unit circle at the origin, signed fixed point with FRAC_BITS
// fraction bits (Q16.16 by default). Takes one ray per cycle unless
// back-pressure holds in_ready low. The pipeline is the square root, which
// resolves two root digits per stage, plus three stages ahead of it (products,
// dot/cross, radicand) and three after it (distance, scaling products, sum and
// saturation). Back-pressure on the output stalls only the stages that are
// full; empty stages keep filling.
// Depends on ruci_pkg and ruci_sqrt.
module ray_unit_circle_intersect_unit #(
  parameter int unsigned COORD_WIDTH = 32,
  parameter int unsigned FRAC_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [COORD_WIDTH-1:0]  in_origin_x,
  input  logic signed [COORD_WIDTH-1:0]  in_origin_y,
  input  logic signed [FRAC_BITS+1:0]    in_dir_x,
  input  logic signed [FRAC_BITS+1:0]    in_dir_y,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_hit,
  output logic signed [COORD_WIDTH-1:0]  out_hit_x,
  output logic signed [COORD_WIDTH-1:0]  out_hit_y,
  output logic signed [FRAC_BITS+1:0]    out_normal_x,
  output logic signed [FRAC_BITS+1:0]    out_normal_y
);

  localparam int unsigned W     = COORD_WIDTH;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned DW    = F + 2;
  localparam int unsigned PRW   = W + DW;        // single product
  localparam int unsigned SW    = PRW + 1;       // dot / cross sum
  localparam int unsigned NW    = SW + 1;        // negated dot
  localparam int unsigned TQW   = NW - F;        // floored distance along ray
  localparam int unsigned CQW   = F + 2;         // floored cross, in [-1, 1]
  localparam int unsigned SQW   = 2 * F + 4;     // cross squared
  localparam int unsigned NDIG  = F + 1;         // root digits
  localparam int unsigned RADW  = 2 * NDIG;
  localparam int unsigned TW    = TQW + 1;
  localparam int unsigned MW    = TW + DW;
  localparam int unsigned JW    = MW - F + 1;
  localparam int unsigned SBW   = 1 + TQW + 2 * W + 2 * DW;
  localparam int unsigned DEPTH = 6 + ruci_pkg::sqrt_stages(NDIG);
  localparam int unsigned CW    = $clog2(DEPTH + 1) + 1;

  localparam logic signed [SW-1:0]  C_POS = {{(SW-2*F-1){1'b0}}, 1'b1, {(2*F){1'b0}}};
  localparam logic signed [SW-1:0]  C_NEG = {{(SW-2*F){1'b1}}, {(2*F){1'b0}}};
  localparam logic signed [SQW-1:0] ONE_SQ = {3'b000, 1'b1, {(2*F){1'b0}}};
  localparam logic signed [JW-1:0]  J_MAX = {{(JW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [JW-1:0]  J_MIN = {{(JW-W+1){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [JW-1:0]  N_MAX = {{(JW-F-1){1'b0}}, 1'b1, {F{1'b0}}};
  localparam logic signed [JW-1:0]  N_MIN = {{(JW-F){1'b1}}, {F{1'b0}}};

  // ---------------- handshake chain ----------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic sq_in_ready, sq_out_valid;

  assign rdy6     = !v6_r || out_ready;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || sq_in_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= sq_out_valid;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  // ---------------- stage 1: the four products ----------------
  logic signed [PRW-1:0] dot_a_r, dot_b_r, crs_a_r, crs_b_r;
  logic signed [W-1:0]   ox1_r, oy1_r;
  logic signed [DW-1:0]  dx1_r, dy1_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      dot_a_r <= PRW'(in_dir_x) * PRW'(in_origin_x);
      dot_b_r <= PRW'(in_dir_y) * PRW'(in_origin_y);
      crs_a_r <= PRW'(in_dir_x) * PRW'(in_origin_y);
      crs_b_r <= PRW'(in_dir_y) * PRW'(in_origin_x);
      ox1_r   <= in_origin_x;
      oy1_r   <= in_origin_y;
      dx1_r   <= in_dir_x;
      dy1_r   <= in_dir_y;
    end
  end

  // ---------------- stage 2: dot, cross, miss tests ----------------
  logic signed [SW-1:0]  dot_nxt, crs_nxt;
  logic signed [NW-1:0]  ndot_nxt;
  logic                  miss_nxt;
  logic signed [TQW-1:0] tq2_r;
  logic signed [CQW-1:0] cq2_r;
  logic                  miss2_r;
  logic signed [W-1:0]   ox2_r, oy2_r;
  logic signed [DW-1:0]  dx2_r, dy2_r;

  always_comb begin
    dot_nxt  = SW'(dot_a_r) + SW'(dot_b_r);
    crs_nxt  = SW'(crs_a_r) - SW'(crs_b_r);
    ndot_nxt = NW'(0) - NW'(dot_nxt);
    // exact tests: ray points away, or line passes outside the circle
    miss_nxt = (!dot_nxt[SW-1] && (dot_nxt != '0)) || (crs_nxt > C_POS) || (crs_nxt < C_NEG);
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      tq2_r   <= $signed(ndot_nxt[NW-1:F]);
      cq2_r   <= $signed(crs_nxt[F+CQW-1:F]);
      miss2_r <= miss_nxt;
      ox2_r   <= ox1_r;
      oy2_r   <= oy1_r;
      dx2_r   <= dx1_r;
      dy2_r   <= dy1_r;
    end
  end

  // ---------------- stage 3: radicand 1 - c*c ----------------
  logic signed [SQW-1:0] rad_full_nxt;
  logic [RADW-1:0]       rad3_r;
  logic                  miss3_r;
  logic signed [TQW-1:0] tq3_r;
  logic signed [W-1:0]   ox3_r, oy3_r;
  logic signed [DW-1:0]  dx3_r, dy3_r;

  assign rad_full_nxt = ONE_SQ - SQW'(cq2_r) * SQW'(cq2_r);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      rad3_r  <= rad_full_nxt[RADW-1:0];
      miss3_r <= miss2_r;
      tq3_r   <= tq2_r;
      ox3_r   <= ox2_r;
      oy3_r   <= oy2_r;
      dx3_r   <= dx2_r;
      dy3_r   <= dy2_r;
    end
  end

  // ---------------- square root ----------------
  logic [NDIG-1:0]       sq_root;
  logic [SBW-1:0]        sq_sb;
  logic                  sq_miss;
  logic signed [TQW-1:0] sq_tq;
  logic signed [W-1:0]   sq_ox, sq_oy;
  logic signed [DW-1:0]  sq_dx, sq_dy;

  ruci_sqrt #(
    .DIGITS (NDIG),
    .SBW    (SBW)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_ready  (sq_in_ready),
    .in_rad    (rad3_r),
    .in_sb     ({miss3_r, tq3_r, ox3_r, oy3_r, dx3_r, dy3_r}),
    .out_valid (sq_out_valid),
    .out_ready (rdy4),
    .out_root  (sq_root),
    .out_sb    (sq_sb)
  );

  assign {sq_miss, sq_tq, sq_ox, sq_oy, sq_dx, sq_dy} = sq_sb;

  // ---------------- stage 4: entry distance ----------------
  logic signed [TW-1:0] t4_r;
  logic                 miss4_r;
  logic signed [W-1:0]  ox4_r, oy4_r;
  logic signed [DW-1:0] dx4_r, dy4_r;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      t4_r    <= TW'(sq_tq) - TW'(sq_root);
      miss4_r <= sq_miss;
      ox4_r   <= sq_ox;
      oy4_r   <= sq_oy;
      dx4_r   <= sq_dx;
      dy4_r   <= sq_dy;
    end
  end

  // ---------------- stage 5: t * u ----------------
  logic signed [MW-1:0] mx5_r, my5_r;
  logic                 miss5_r;
  logic signed [W-1:0]  ox5_r, oy5_r;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      mx5_r   <= MW'(t4_r) * MW'(dx4_r);
      my5_r   <= MW'(t4_r) * MW'(dy4_r);
      miss5_r <= miss4_r;
      ox5_r   <= ox4_r;
      oy5_r   <= oy4_r;
    end
  end

  // ---------------- stage 6: point, saturation, output register ----------------
  logic signed [JW-1:0] jx_nxt, jy_nxt, jxc_nxt, jyc_nxt, nx_nxt, ny_nxt;
  logic                 hit_r;
  logic signed [W-1:0]  hit_x_r, hit_y_r;
  logic signed [DW-1:0] normal_x_r, normal_y_r;

  always_comb begin
    jx_nxt  = JW'(ox5_r) + JW'($signed(mx5_r[MW-1:F]));
    jy_nxt  = JW'(oy5_r) + JW'($signed(my5_r[MW-1:F]));
    jxc_nxt = (jx_nxt > J_MAX) ? J_MAX : ((jx_nxt < J_MIN) ? J_MIN : jx_nxt);
    jyc_nxt = (jy_nxt > J_MAX) ? J_MAX : ((jy_nxt < J_MIN) ? J_MIN : jy_nxt);
    nx_nxt  = (jxc_nxt > N_MAX) ? N_MAX : ((jxc_nxt < N_MIN) ? N_MIN : jxc_nxt);
    ny_nxt  = (jyc_nxt > N_MAX) ? N_MAX : ((jyc_nxt < N_MIN) ? N_MIN : jyc_nxt);
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      hit_r      <= !miss5_r;
      hit_x_r    <= miss5_r ? '0 : jxc_nxt[W-1:0];
      hit_y_r    <= miss5_r ? '0 : jyc_nxt[W-1:0];
      normal_x_r <= miss5_r ? '0 : nx_nxt[DW-1:0];
      normal_y_r <= miss5_r ? '0 : ny_nxt[DW-1:0];
    end
  end

  assign out_valid    = v6_r;
  assign out_hit      = hit_r;
  assign out_hit_x    = hit_x_r;
  assign out_hit_y    = hit_y_r;
  assign out_normal_x = normal_x_r;
  assign out_normal_y = normal_y_r;

  // ---------------- checks ----------------
  logic [CW-1:0] inflight_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + CW'(in_valid && in_ready) - CW'(out_valid && out_ready);
    end
  end

  a_depth : assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= CW'(DEPTH))
    else $error("more requests in flight than pipeline stages");

  a_empty : assert property (@(posedge clk) disable iff (!rst_n)
    (inflight_r == '0) |-> !out_valid)
    else $error("result presented with no request in flight");

  a_miss_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> (out_hit_x == '0) && (out_hit_y == '0) &&
                              (out_normal_x == '0) && (out_normal_y == '0))
    else $error("miss with nonzero point");

  a_normal_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (JW'(out_normal_x) <= N_MAX) && (JW'(out_normal_x) >= N_MIN) &&
                  (JW'(out_normal_y) <= N_MAX) && (JW'(out_normal_y) >= N_MIN))
    else $error("normal outside unit range");

endmodule
